@@ sv/ortt_pkg.sv @@
// Package for the outstanding request timeout table: widths, codes, types.
// Used by every module and interface of the block but ortt_ram; depends on nothing.
package ortt_pkg;

   // Default sizing of the slot memory
   localparam int PROCS_DEF    = 4;
   localparam int SLOTS_DEF    = 16;
   localparam int TAG_BITS_DEF = 8;

   // Fixed field widths of the channels
   localparam int KIND_W   = 2;
   localparam int PROC_W   = 2;
   localparam int TAG_W    = 8;
   localparam int TIME_W   = 64;
   localparam int STATUS_W = 3;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam int THR_W      = 32;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = '0;
   localparam logic [THR_W-1:0]     THR_RESET     = 32'd100000;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_CHECK  = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 3'd0,
      ST_DUP  = 3'd1,
      ST_MISS = 3'd2,
      ST_FULL = 3'd3,
      ST_LATE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PROC_W-1:0]   late_proc;
      logic [TAG_W-1:0]    late_tag;
      logic [TIME_W-1:0]   late_request_time;
   } result_type;

endpackage

@@ sv/ortt_req_if.sv @@
// Request channel of the outstanding request timeout table.
// Depends on ortt_pkg for the field widths.
interface ortt_req_if;
   logic                        valid;
   logic                        ready;
   logic [ortt_pkg::KIND_W-1:0] kind;
   logic [ortt_pkg::PROC_W-1:0] proc;
   logic [ortt_pkg::TAG_W-1:0]  tag;
   logic [ortt_pkg::TIME_W-1:0] now_time;

   modport source (output valid, kind, proc, tag, now_time, input ready);
   modport sink   (input valid, kind, proc, tag, now_time, output ready);
endinterface

@@ sv/ortt_rsp_if.sv @@
// Response channel of the outstanding request timeout table.
// Depends on ortt_pkg for the field widths.
interface ortt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ortt_pkg::STATUS_W-1:0] status;
   logic [ortt_pkg::PROC_W-1:0]   late_proc;
   logic [ortt_pkg::TAG_W-1:0]    late_tag;
   logic [ortt_pkg::TIME_W-1:0]   late_request_time;

   modport source (output valid, status, late_proc, late_tag, late_request_time,
                   input ready);
   modport sink   (input valid, status, late_proc, late_tag, late_request_time,
                   output ready);
endinterface

@@ sv/ortt_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module ortt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/ortt_csr.sv @@
// Register block of the timeout table: holds the response threshold.
// Depends on ortt_pkg for address width, register index and reset value.
module ortt_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ortt_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [ortt_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [ortt_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output logic [ortt_pkg::THR_W-1:0]        threshold
);

   localparam int AW = ortt_pkg::CSR_ADDR_W;
   localparam int IW = ortt_pkg::CSR_IDX_W;

   logic [ortt_pkg::THR_W-1:0] thr_ff, thr_in;
   logic [IW-1:0]              index;
   logic                       wr_go;

   assign index = paddr[AW-1:2];
   assign wr_go = psel && penable && pwrite;

   always_comb begin
      thr_in = thr_ff;
      if (wr_go && (index == ortt_pkg::REG_THRESHOLD)) begin
         thr_in = pwdata[ortt_pkg::THR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ortt_pkg::THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign prdata    = (index == ortt_pkg::REG_THRESHOLD) ? thr_ff : '0;
   assign pready    = 1'b1;
   assign threshold = thr_ff;

endmodule

@@ sv/ortt_engine.sv @@
// Scan engine of the timeout table: clears the slot memory after reset,
// sequences reads of it, folds each entry into match/free/late trackers
// and writes back inserts and deletes. Depends on ortt_pkg and ortt_req_if.
module ortt_engine #(
   parameter int PROCS          = ortt_pkg::PROCS_DEF,
   parameter int SLOTS_PER_PROC = ortt_pkg::SLOTS_DEF,
   parameter int TAG_BITS       = ortt_pkg::TAG_BITS_DEF,
   localparam int TOTAL = PROCS * SLOTS_PER_PROC,
   localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1,
   localparam int EW    = 1 + TAG_BITS + ortt_pkg::TIME_W
) (
   input  logic                       clock,
   input  logic                       reset,
   ortt_req_if.sink                   req_chan,
   input  logic [ortt_pkg::THR_W-1:0] threshold,
   output logic                       ram_we,
   output logic [AW-1:0]              ram_waddr,
   output logic [EW-1:0]              ram_wdata,
   output logic [AW-1:0]              ram_raddr,
   input  logic [EW-1:0]              ram_rdata,
   output logic                       res_valid,
   input  logic                       res_ready,
   output ortt_pkg::result_type       res_data
);

   localparam int PW     = (PROCS > 1) ? $clog2(PROCS) : 1;
   localparam int SW     = (SLOTS_PER_PROC > 1) ? $clog2(SLOTS_PER_PROC) : 1;
   localparam int TW     = ortt_pkg::TIME_W;
   localparam int KW     = ortt_pkg::KIND_W;
   localparam int PROC_W = ortt_pkg::PROC_W;
   localparam int TAG_W  = ortt_pkg::TAG_W;

   ortt_pkg::state_type state_ff, state_in;

   logic [KW-1:0]       kind_ff, kind_in;
   logic [PROC_W-1:0]   proc_ff, proc_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic [TW-1:0]       now_ff, now_in;

   logic [AW-1:0] addr_ff, addr_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [PW-1:0] sproc_ff, sproc_in;

   logic          d_vld_ff, d_vld_in;
   logic [AW-1:0] d_addr_ff, d_addr_in;
   logic [PW-1:0] d_proc_ff, d_proc_in;

   logic                hit_ff, hit_in;
   logic [AW-1:0]       hit_addr_ff, hit_addr_in;
   logic                free_ff, free_in;
   logic [AW-1:0]       free_addr_ff, free_addr_in;
   logic                best_ff, best_in;
   logic [PW-1:0]       best_proc_ff, best_proc_in;
   logic [TAG_BITS-1:0] best_tag_ff, best_tag_in;
   logic [TW-1:0]       best_time_ff, best_time_in;

   logic                rd_valid;
   logic [TAG_BITS-1:0] rd_tag;
   logic [TW-1:0]       rd_time;
   logic                tag_match;
   logic                late;
   logic                proc_ok;
   logic                req_proc_ok;
   logic                last_slot;
   logic                last_proc;
   logic                last_addr;
   logic                scan_last;

   assign rd_valid  = ram_rdata[EW-1];
   assign rd_tag    = ram_rdata[TW +: TAG_BITS];
   assign rd_time   = ram_rdata[TW-1:0];
   assign tag_match = rd_valid && (rd_tag == tag_ff);
   assign late      = rd_valid && ((now_ff - rd_time) > TW'(threshold));

   assign proc_ok     = 32'(proc_ff) < PROCS;
   assign req_proc_ok = 32'(req_chan.proc) < PROCS;
   assign last_slot   = slot_ff == SW'(SLOTS_PER_PROC - 1);
   assign last_proc   = sproc_ff == PW'(PROCS - 1);
   assign last_addr   = addr_ff == AW'(TOTAL - 1);
   assign scan_last   = (kind_ff == ortt_pkg::KIND_CHECK) ? (last_slot && last_proc)
                                                          : last_slot;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      proc_in      = proc_ff;
      tag_in       = tag_ff;
      now_in       = now_ff;
      addr_in      = addr_ff;
      slot_in      = slot_ff;
      sproc_in     = sproc_ff;
      d_vld_in     = 1'b0;
      d_addr_in    = addr_ff;
      d_proc_in    = sproc_ff;
      hit_in       = hit_ff;
      hit_addr_in  = hit_addr_ff;
      free_in      = free_ff;
      free_addr_in = free_addr_ff;
      best_in      = best_ff;
      best_proc_in = best_proc_ff;
      best_tag_in  = best_tag_ff;
      best_time_in = best_time_ff;

      ram_we    = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = '0;
      ram_raddr = addr_ff;
      req_chan.ready = 1'b0;
      res_valid = 1'b0;
      res_data  = '0;

      // Fold the entry read last cycle into the trackers
      if (d_vld_ff) begin
         if (tag_match && !hit_ff) begin
            hit_in      = 1'b1;
            hit_addr_in = d_addr_ff;
         end
         if (!rd_valid && !free_ff) begin
            free_in      = 1'b1;
            free_addr_in = d_addr_ff;
         end
         // Earlier processors win; within one, the lowest tag wins
         if (late && (!best_ff || ((d_proc_ff == best_proc_ff) &&
                                   (rd_tag < best_tag_ff)))) begin
            best_in      = 1'b1;
            best_proc_in = d_proc_ff;
            best_tag_in  = rd_tag;
            best_time_in = rd_time;
         end
      end

      case (state_ff)
         ortt_pkg::S_CLEAR: begin
            ram_we = 1'b1;
            if (last_addr) begin
               addr_in  = '0;
               state_in = ortt_pkg::S_IDLE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         ortt_pkg::S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               kind_in  = req_chan.kind;
               proc_in  = req_chan.proc;
               tag_in   = TAG_BITS'(req_chan.tag);
               now_in   = req_chan.now_time;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               best_in  = 1'b0;
               slot_in  = '0;
               sproc_in = '0;
               if (req_chan.kind == ortt_pkg::KIND_CHECK) begin
                  addr_in  = '0;
                  state_in = ortt_pkg::S_SCAN;
               end else if (((req_chan.kind == ortt_pkg::KIND_INSERT) ||
                             (req_chan.kind == ortt_pkg::KIND_DELETE)) && req_proc_ok) begin
                  addr_in  = AW'(32'(req_chan.proc) * SLOTS_PER_PROC);
                  state_in = ortt_pkg::S_SCAN;
               end else begin
                  state_in = ortt_pkg::S_FINISH;
               end
            end
         end
         ortt_pkg::S_SCAN: begin
            d_vld_in  = 1'b1;
            d_addr_in = addr_ff;
            d_proc_in = sproc_ff;
            if (scan_last) begin
               state_in = ortt_pkg::S_DRAIN;
            end else begin
               addr_in = addr_ff + AW'(1);
               if (last_slot) begin
                  slot_in  = '0;
                  sproc_in = sproc_ff + PW'(1);
               end else begin
                  slot_in = slot_ff + SW'(1);
               end
            end
         end
         ortt_pkg::S_DRAIN: begin
            state_in = ortt_pkg::S_FINISH;
         end
         ortt_pkg::S_FINISH: begin
            res_valid = 1'b1;
            res_data.status = ortt_pkg::ST_OK;
            case (kind_ff)
               ortt_pkg::KIND_INSERT: begin
                  if (!proc_ok) begin
                     res_data.status = ortt_pkg::ST_FULL;
                  end else if (hit_ff) begin
                     res_data.status = ortt_pkg::ST_DUP;
                  end else if (free_ff) begin
                     ram_we    = res_ready;
                     ram_waddr = free_addr_ff;
                     ram_wdata = {1'b1, tag_ff, now_ff};
                  end else begin
                     res_data.status = ortt_pkg::ST_FULL;
                  end
               end
               ortt_pkg::KIND_DELETE: begin
                  if (proc_ok && hit_ff) begin
                     ram_we    = res_ready;
                     ram_waddr = hit_addr_ff;
                     ram_wdata = '0;
                  end else begin
                     res_data.status = ortt_pkg::ST_MISS;
                  end
               end
               ortt_pkg::KIND_CHECK: begin
                  if (best_ff) begin
                     res_data.status            = ortt_pkg::ST_LATE;
                     res_data.late_proc         = PROC_W'(best_proc_ff);
                     res_data.late_tag          = TAG_W'(best_tag_ff);
                     res_data.late_request_time = best_time_ff;
                  end
               end
               default: begin
                  res_data.status = ortt_pkg::ST_OK;
               end
            endcase
            if (res_ready) begin
               state_in = ortt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ortt_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ortt_pkg::S_CLEAR;
         addr_ff  <= '0;
         slot_ff  <= '0;
         sproc_ff <= '0;
         d_vld_ff <= 1'b0;
         hit_ff   <= 1'b0;
         free_ff  <= 1'b0;
         best_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         slot_ff  <= slot_in;
         sproc_ff <= sproc_in;
         d_vld_ff <= d_vld_in;
         hit_ff   <= hit_in;
         free_ff  <= free_in;
         best_ff  <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      proc_ff      <= proc_in;
      tag_ff       <= tag_in;
      now_ff       <= now_in;
      d_addr_ff    <= d_addr_in;
      d_proc_ff    <= d_proc_in;
      hit_addr_ff  <= hit_addr_in;
      free_addr_ff <= free_addr_in;
      best_proc_ff <= best_proc_in;
      best_tag_ff  <= best_tag_in;
      best_time_ff <= best_time_in;
   end

endmodule

@@ sv/outstanding_request_timeout_table.sv @@
// Top level of the outstanding request timeout table: slot memory, scan
// engine, register block and response register.
// Depends on ortt_pkg, ortt_req_if, ortt_rsp_if, ortt_ram, ortt_csr, ortt_engine.
//
// Usage:
//   req_chan carries one command per transfer: insert (proc, tag, now_time as
//   request time), delete (proc, tag) or check (now_time as current time).
//   rsp_chan returns exactly one result per command: status and, for a
//   timeout found, the processor, tag and request time of the first late
//   entry (lowest processor, then lowest tag). The csr_ port holds the
//   response threshold at byte address 0.
//   Scan: every entry is read from one slot memory, one read per cycle.
//   Insert and delete scan one processor's slots; a check scans all
//   PROCS * SLOTS_PER_PROC entries. An unknown kind, or insert/delete to a
//   missing processor, skips the scan. The engine takes no new command until
//   it has handed over the result, which shows on rsp_chan in the same cycle
//   in which the engine is ready for the next command.
//   Reset: the threshold returns to 100000 and a clearing pass writes every
//   slot empty, with req_chan.ready low.
//   Stall: a result waits in the response register; the engine finishes the
//   next command and holds it until that register frees up.
module outstanding_request_timeout_table #(
   parameter int PROCS          = ortt_pkg::PROCS_DEF,
   parameter int SLOTS_PER_PROC = ortt_pkg::SLOTS_DEF,
   parameter int TAG_BITS       = ortt_pkg::TAG_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   ortt_req_if.sink                        req_chan,
   ortt_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ortt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ortt_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ortt_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int TOTAL = PROCS * SLOTS_PER_PROC;
   localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int EW    = 1 + TAG_BITS + ortt_pkg::TIME_W;

   logic [ortt_pkg::THR_W-1:0] threshold;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [EW-1:0] ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [EW-1:0] ram_rdata;

   logic                 res_valid;
   logic                 res_ready;
   ortt_pkg::result_type res_data;

   logic                 rsp_valid_ff, rsp_valid_in;
   ortt_pkg::result_type rsp_data_ff, rsp_data_in;

   ortt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .threshold (threshold)
   );

   // Slot memory: {valid, tag, request time} per entry
   ortt_ram #(
      .WIDTH (EW),
      .DEPTH (TOTAL)
   ) u_slots (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ortt_engine #(
      .PROCS          (PROCS),
      .SLOTS_PER_PROC (SLOTS_PER_PROC),
      .TAG_BITS       (TAG_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .threshold (threshold),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

   // Response register: load when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.status            = rsp_data_ff.status;
   assign rsp_chan.late_proc         = rsp_data_ff.late_proc;
   assign rsp_chan.late_tag          = rsp_data_ff.late_tag;
   assign rsp_chan.late_request_time = rsp_data_ff.late_request_time;

endmodule

@@ sv/ortt_chk.sv @@
// Port-level checker for the outstanding request timeout table, bound to the top.
// Depends on ortt_pkg for widths and status codes.
module ortt_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ortt_pkg::STATUS_W-1:0] rsp_status,
   input logic [ortt_pkg::PROC_W-1:0]   rsp_late_proc,
   input logic [ortt_pkg::TAG_W-1:0]    rsp_late_tag,
   input logic [ortt_pkg::TIME_W-1:0]   rsp_late_request_time
);

   // Clearing pass follows reset: no transfer taken right after it
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request taken during clearing pass");

   // One command at a time: ready drops after each transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second command taken while one is in flight");

   // A result never shows in the cycle right after its command is taken
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("response appeared without a scan");

   // Late fields stay zero unless a timeout is reported
   a_late_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ortt_pkg::ST_LATE)) |->
         ((rsp_late_proc == '0) && (rsp_late_tag == '0) &&
          (rsp_late_request_time == '0)))
      else $error("late fields set without a timeout");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)))
      else $error("stalled response dropped or changed");

endmodule

bind outstanding_request_timeout_table ortt_chk u_ortt_chk (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_chan.valid),
   .req_ready             (req_chan.ready),
   .rsp_valid             (rsp_chan.valid),
   .rsp_ready             (rsp_chan.ready),
   .rsp_status            (rsp_chan.status),
   .rsp_late_proc         (rsp_chan.late_proc),
   .rsp_late_tag          (rsp_chan.late_tag),
   .rsp_late_request_time (rsp_chan.late_request_time)
);
